### hw/rtl/acpipm_pkg.sv
// ----------------------------------------------------------------------------
// acpipm_pkg
// types and constants for the acpi pm1 event and control register block
// ----------------------------------------------------------------------------
package acpipm_pkg;

    typedef enum logic [1:0] {
        CMD_READ   = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_PWRBTN = 2'd2,
        CMD_WAKE   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        SEL_STATUS  = 3'd0,
        SEL_ENABLE  = 3'd1,
        SEL_CONTROL = 3'd2,
        SEL_SMI     = 3'd3,
        SEL_RESET   = 3'd4
    } sel_t;

    typedef enum logic [0:0] {
        CFG_ENABLE_CODE  = 1'b0,
        CFG_DISABLE_CODE = 1'b1
    } cfg_idx_t;

    localparam logic [15:0] STS_TMR    = 16'h0001;
    localparam logic [15:0] STS_BM     = 16'h0010;
    localparam logic [15:0] STS_GBL    = 16'h0020;
    localparam logic [15:0] STS_PWRBTN = 16'h0100;
    localparam logic [15:0] STS_SLPBTN = 16'h0200;
    localparam logic [15:0] STS_RTC    = 16'h0400;
    localparam logic [15:0] STS_WAK    = 16'h8000;

    localparam logic [15:0] CLEARABLE  = STS_WAK | STS_RTC | STS_SLPBTN | STS_PWRBTN | STS_BM;
    localparam logic [15:0] ENABLE_OK  = STS_RTC | STS_PWRBTN | STS_GBL;
    localparam logic [15:0] SCI_SRC    = STS_TMR | STS_GBL | STS_PWRBTN | STS_SLPBTN | STS_RTC;

    localparam logic [15:0] CTL_SCI_EN = 16'h0001;
    localparam logic [15:0] CTL_SLP_EN = 16'h2000;
    localparam logic [15:0] CTL_ZERO   = 16'hc003;
    localparam logic [2:0]  SLP_TYP_OFF     = 3'd5;
    localparam logic [2:0]  SLP_TYP_SUSPEND = 3'd3;

    localparam logic [2:0] SIZE_WORD = 3'd2;
    localparam logic [2:0] SIZE_BYTE = 3'd1;

    localparam int RST_FULL_BIT = 3;
    localparam int RST_SYS_BIT  = 2;

    localparam logic [7:0] ENABLE_CODE_RST  = 8'd160;
    localparam logic [7:0] DISABLE_CODE_RST = 8'd161;

    typedef struct packed {
        logic [15:0] read_data;
        logic        access_error;
        logic        sci_level;
        logic        poweroff_req;
        logic        suspend_req;
        logic        system_reset_req;
        logic        full_reset_req;
    } result_t;

endpackage

### hw/rtl/acpi_pm1_event_control_regs_core.sv
// ----------------------------------------------------------------------------
// acpi_pm1_event_control_regs_core
// acpi pm1 status, enable, control, smi command and reset control registers
// ----------------------------------------------------------------------------
// usage:
//   s_* is the request channel: each transaction is a register read, a
//   register write, a power button press or a wake event. m_* returns one
//   result per request: read data, access error, the sci line level after
//   the request, and one-transaction pulses for poweroff, suspend, system
//   reset and full reset.
//   cfg_* sets the smi enable and disable codes; write it only while idle.
// result path and throughput:
//   the register update and the result are formed in the accept cycle; the
//   result is registered and shown on m_*. one request per cycle is sustained
//   while s_ready is high; the only work per request is one masked register update.
// reset:
//   aresetn low clears all registers to zero, the smi codes to 160 and 161
//   and empties the result buffers.
// stalls:
//   a two-entry output buffer (result register plus skid register) lets a
//   request be accepted while a result waits; s_ready drops only when both
//   hold results.
// ----------------------------------------------------------------------------
module acpi_pm1_event_control_regs_core (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [2:0]  s_reg_sel,
    input  logic [2:0]  s_access_bytes,
    input  logic [15:0] s_write_data,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_read_data,
    output logic        m_access_error,
    output logic        m_sci_level,
    output logic        m_poweroff_req,
    output logic        m_suspend_req,
    output logic        m_system_reset_req,
    output logic        m_full_reset_req,

    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_wr_data
);

    logic [7:0]  enable_code_reg;
    logic [7:0]  disable_code_reg;
    logic [15:0] status_reg, status_next;
    logic [15:0] enable_reg, enable_next;
    logic [15:0] control_reg, control_next;
    logic [7:0]  reset_byte_reg, reset_byte_next;
    logic        sci_reg, sci_next;

    acpipm_pkg::result_t res_next;
    acpipm_pkg::result_t out_reg;
    acpipm_pkg::result_t skid_reg;
    logic                out_valid_reg;
    logic                skid_valid_reg;

    logic        accept;
    logic        refresh;
    logic [15:0] ctl_wr;
    logic [2:0]  slp_typ;
    logic [7:0]  data_byte;

    assign s_ready   = !skid_valid_reg;
    assign accept    = s_valid && s_ready;
    assign ctl_wr    = (control_reg & acpipm_pkg::CTL_SCI_EN)
                     | (s_write_data & ~(acpipm_pkg::CTL_SLP_EN | acpipm_pkg::CTL_ZERO));
    assign slp_typ   = ctl_wr[12:10];
    assign data_byte = s_write_data[7:0];

    // request decode and register update
    always_comb begin
        status_next     = status_reg;
        enable_next     = enable_reg;
        control_next    = control_reg;
        reset_byte_next = reset_byte_reg;
        refresh         = 1'b0;
        res_next        = '0;

        case (acpipm_pkg::cmd_t'(s_cmd))
            acpipm_pkg::CMD_PWRBTN: begin
                if ((status_reg & acpipm_pkg::STS_PWRBTN) == 16'h0) begin
                    status_next = status_reg | acpipm_pkg::STS_PWRBTN;
                    refresh     = 1'b1;
                end
            end
            acpipm_pkg::CMD_WAKE: begin
                status_next = status_reg | acpipm_pkg::STS_WAK;
            end
            default: begin
                case (s_reg_sel)
                    acpipm_pkg::SEL_STATUS, acpipm_pkg::SEL_ENABLE,
                    acpipm_pkg::SEL_CONTROL: begin
                        if (s_access_bytes != acpipm_pkg::SIZE_WORD) begin
                            res_next.access_error = 1'b1;
                        end else if (s_cmd == acpipm_pkg::CMD_READ) begin
                            case (s_reg_sel)
                                acpipm_pkg::SEL_STATUS: res_next.read_data = status_reg;
                                acpipm_pkg::SEL_ENABLE: res_next.read_data = enable_reg;
                                default:                res_next.read_data = control_reg;
                            endcase
                        end else begin
                            case (s_reg_sel)
                                acpipm_pkg::SEL_STATUS: begin
                                    status_next = status_reg
                                                & ~(s_write_data & acpipm_pkg::CLEARABLE);
                                    refresh     = 1'b1;
                                end
                                acpipm_pkg::SEL_ENABLE: begin
                                    enable_next = s_write_data & acpipm_pkg::ENABLE_OK;
                                    refresh     = 1'b1;
                                end
                                default: begin
                                    control_next = ctl_wr;
                                    if ((s_write_data & acpipm_pkg::CTL_SLP_EN) != 16'h0) begin
                                        res_next.poweroff_req =
                                            (slp_typ == acpipm_pkg::SLP_TYP_OFF);
                                        res_next.suspend_req =
                                            (slp_typ == acpipm_pkg::SLP_TYP_SUSPEND);
                                    end
                                end
                            endcase
                        end
                    end
                    acpipm_pkg::SEL_SMI: begin
                        if (s_cmd == acpipm_pkg::CMD_READ ||
                            s_access_bytes != acpipm_pkg::SIZE_BYTE) begin
                            res_next.access_error = 1'b1;
                        end else if (data_byte == enable_code_reg) begin
                            control_next = control_reg | acpipm_pkg::CTL_SCI_EN;
                        end else if (data_byte == disable_code_reg) begin
                            control_next = control_reg & ~acpipm_pkg::CTL_SCI_EN;
                        end
                    end
                    acpipm_pkg::SEL_RESET: begin
                        if (s_access_bytes != acpipm_pkg::SIZE_BYTE) begin
                            res_next.access_error = 1'b1;
                        end else if (s_cmd == acpipm_pkg::CMD_READ) begin
                            res_next.read_data = {8'h00, reset_byte_reg};
                        end else if (s_write_data[acpipm_pkg::RST_FULL_BIT]) begin
                            reset_byte_next         = 8'h00;
                            res_next.full_reset_req = 1'b1;
                        end else begin
                            reset_byte_next           = data_byte;
                            res_next.system_reset_req = s_write_data[acpipm_pkg::RST_SYS_BIT];
                        end
                    end
                    default: ;
                endcase
            end
        endcase

        // sci is recomputed from enabled status only while sci_en is set; else it holds
        sci_next = sci_reg;
        if (refresh && control_reg[0]) begin
            sci_next = |(status_next & enable_next & acpipm_pkg::SCI_SRC);
        end
        res_next.sci_level = sci_next;
    end

    // register file and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg       <= '0;
            enable_reg       <= '0;
            control_reg      <= '0;
            reset_byte_reg   <= '0;
            sci_reg          <= 1'b0;
            enable_code_reg  <= acpipm_pkg::ENABLE_CODE_RST;
            disable_code_reg <= acpipm_pkg::DISABLE_CODE_RST;
        end else begin
            if (accept) begin
                status_reg     <= status_next;
                enable_reg     <= enable_next;
                control_reg    <= control_next;
                reset_byte_reg <= reset_byte_next;
                sci_reg        <= sci_next;
            end
            if (cfg_wr_en) begin
                case (acpipm_pkg::cfg_idx_t'(cfg_index))
                    acpipm_pkg::CFG_ENABLE_CODE:  enable_code_reg  <= cfg_wr_data;
                    acpipm_pkg::CFG_DISABLE_CODE: disable_code_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
        end
    end

    // result register with skid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!out_valid_reg || m_ready) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= accept;
                end
            end else if (accept) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (accept) begin
                out_reg <= res_next;
            end
        end else if (accept) begin
            skid_reg <= res_next;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_read_data        = out_reg.read_data;
    assign m_access_error     = out_reg.access_error;
    assign m_sci_level        = out_reg.sci_level;
    assign m_poweroff_req     = out_reg.poweroff_req;
    assign m_suspend_req      = out_reg.suspend_req;
    assign m_system_reset_req = out_reg.system_reset_req;
    assign m_full_reset_req   = out_reg.full_reset_req;

endmodule
